// File: hdl/interval_overlap_store_assert.svh
// assertion macros shared by the rtl
`ifndef INTERVAL_OVERLAP_STORE_ASSERT_SVH
`define INTERVAL_OVERLAP_STORE_ASSERT_SVH

// implication checked in the same cycle
`define IOS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ios check failed");

// implication checked in the next cycle
`define IOS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ios check failed");

`endif

// File: hdl/iovs_pkg.sv
package iovs_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_SETEND = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_COUNT  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_FIN
    } back_state_t;

    localparam int TIME_W   = 63;
    localparam int HANDLE_W = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MATCH   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;

    // classified command handed from front to back
    typedef struct packed {
        action_t             action;
        logic [KIND_W-1:0]   kind;
        logic                kind_ok;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   start_time;
        logic [TIME_W-1:0]   end_time;
    } cmd_t;

endpackage

// File: hdl/interval_overlap_store.sv
// Interval store with up to CAPACITY typed entries, filled from slot 0 and never freed.
// Commands arrive on s_axis, results leave on m_axis; a two-entry command queue
// separates the input from the execution engine. An insert goes from IDLE to FIN and is
// answered through the output register; set end, lookup and count scan the filled slots
// through one registered memory read port, one slot per cycle unless the result side
// stalls a lookup. A lookup emits one result per matching slot in slot order, the last
// with tlast set, or a single no-match result. message_kind is written on the cfg channel
// only while the block is idle; the user must keep to this, the block does not enforce it.
module interval_overlap_store #(
    parameter int CAPACITY  = 64,
    parameter int NUM_KINDS = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    // command stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [3:0]   s_axis_tuser,  // action[1:0], kind[3:2]
    input  logic [143:0] s_axis_tdata,  // handle[15:0], start_time[78:16], end_time[141:79]
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [2:0]   m_axis_tuser,  // status[2:0]
    output logic [23:0]  m_axis_tdata,  // found_handle[15:0], count[22:16]
    output logic         m_axis_tlast,
    // configuration write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_data
);
    import iovs_pkg::*;

    logic              cmd_valid, cmd_ready;
    cmd_t              cmd;
    logic [KIND_W-1:0] msg_kind_reg;
    logic [HANDLE_W-1:0] res_handle;
    logic [COUNT_W-1:0]  res_count;

    // message kind register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            msg_kind_reg <= '0;
        end
        else if (cfg_valid)
        begin
            msg_kind_reg <= cfg_data;
        end
    end

    iovs_front #(
        .NUM_KINDS (NUM_KINDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_user   (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    iovs_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .msg_kind   (msg_kind_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (m_axis_tuser),
        .out_handle (res_handle),
        .out_count  (res_count),
        .out_last   (m_axis_tlast)
    );

    // pack result fields
    assign m_axis_tdata = {1'b0, res_count, res_handle};

endmodule

// File: hdl/iovs_front.sv
module iovs_front #(
    parameter int NUM_KINDS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [3:0]    in_user,
    input  logic [143:0]  in_data,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output iovs_pkg::cmd_t cmd
);
    import iovs_pkg::*;

    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       new_cmd;
    logic       push, pop;

    // classify the incoming transaction
    always_comb
    begin
        new_cmd.action     = action_t'(in_user[1:0]);
        new_cmd.kind       = in_user[3:2];
        new_cmd.kind_ok    = 32'(in_user[3:2]) < NUM_KINDS;
        new_cmd.handle     = in_data[15:0];
        new_cmd.start_time = in_data[78:16];
        new_cmd.end_time   = in_data[141:79];
    end

    // two-entry queue towards the back end
    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// File: hdl/iovs_back.sv
module iovs_back #(
    parameter int CAPACITY = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  iovs_pkg::cmd_t                cmd,
    input  logic [iovs_pkg::KIND_W-1:0]   msg_kind,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [iovs_pkg::STATUS_W-1:0] out_status,
    output logic [iovs_pkg::HANDLE_W-1:0] out_handle,
    output logic [iovs_pkg::COUNT_W-1:0]  out_count,
    output logic                          out_last
);
    import iovs_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int FILL_W = $clog2(CAPACITY + 1);

    // slot memories
    logic [KIND_W-1:0]   kind_mem   [CAPACITY];
    logic [HANDLE_W-1:0] handle_mem [CAPACITY];
    logic [TIME_W-1:0]   start_mem  [CAPACITY];
    logic [TIME_W-1:0]   end_mem    [CAPACITY];

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [FILL_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]    rd_idx_reg;
    logic [KIND_W-1:0]   rd_kind_reg;
    logic [HANDLE_W-1:0] rd_handle_reg;
    logic [TIME_W-1:0]   rd_start_reg, rd_end_reg;
    logic [COUNT_W-1:0]  cnt_reg, cnt_next;
    logic                pend_v_reg, pend_v_next;
    logic [HANDLE_W-1:0] pend_handle_reg, pend_handle_next;
    logic [COUNT_W-1:0]  pend_count_reg, pend_count_next;
    logic [STATUS_W-1:0] fin_status_reg, fin_status_next;
    logic [HANDLE_W-1:0] fin_handle_reg, fin_handle_next;
    logic [COUNT_W-1:0]  fin_count_reg, fin_count_next;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic                out_last_reg;

    logic                out_free, take, store_full;
    logic                kind_hit, point_always, overlap, hit, handle_hit;
    logic                stall, issue, drained, setend_done;
    logic                wr_en, wr_full;
    logic [IDX_W-1:0]    wr_addr;
    logic [TIME_W-1:0]   wr_end;
    logic                emit;
    logic [STATUS_W-1:0] emit_status;
    logic [HANDLE_W-1:0] emit_handle;
    logic [COUNT_W-1:0]  emit_count;
    logic                emit_last;

    assign out_free   = !out_valid_reg || out_ready;
    assign cmd_ready  = (state_reg == B_IDLE);
    assign take       = cmd_valid && cmd_ready;
    assign store_full = (fill_reg == FILL_W'(CAPACITY));

    // evaluate the slot held in the read registers
    always_comb
    begin
        kind_hit     = rd_vld_reg && cmd_reg.kind_ok && (rd_kind_reg == cmd_reg.kind);
        point_always = (rd_start_reg == rd_end_reg) && (rd_kind_reg != msg_kind);
        overlap      = ((rd_start_reg >= cmd_reg.start_time) &&
                        (rd_start_reg <= cmd_reg.end_time)) ||
                       ((rd_end_reg >= cmd_reg.start_time) &&
                        (rd_end_reg <= cmd_reg.end_time)) ||
                       ((rd_start_reg < cmd_reg.start_time) &&
                        (rd_end_reg > cmd_reg.end_time));
        hit          = kind_hit && (point_always || overlap);
        handle_hit   = rd_vld_reg && (rd_handle_reg == cmd_reg.handle);
        setend_done  = (state_reg == B_SCAN) && (cmd_reg.action == ACT_SETEND) && handle_hit;
        stall        = (cmd_reg.action == ACT_LOOKUP) && hit && pend_v_reg && !out_free;
        issue        = (state_reg == B_SCAN) && !stall && (scan_idx_reg < fill_reg) &&
                       !setend_done;
        drained      = (scan_idx_reg == fill_reg) && !rd_vld_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    state_next = (cmd.action == ACT_INSERT) ? B_FIN : B_SCAN;
                end
            end
            B_SCAN:
            begin
                if (setend_done || drained)
                begin
                    state_next = B_FIN;
                end
            end
            B_FIN:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb
    begin
        fill_next        = fill_reg;
        scan_idx_next    = scan_idx_reg;
        rd_vld_next      = rd_vld_reg;
        cnt_next         = cnt_reg;
        pend_v_next      = pend_v_reg;
        pend_handle_next = pend_handle_reg;
        pend_count_next  = pend_count_reg;
        fin_status_next  = fin_status_reg;
        fin_handle_next  = fin_handle_reg;
        fin_count_next   = fin_count_reg;
        wr_en            = 1'b0;
        wr_full          = 1'b0;
        wr_addr          = fill_reg[IDX_W-1:0];
        wr_end           = cmd.end_time;
        emit             = 1'b0;
        emit_status      = ST_MATCH;
        emit_handle      = pend_handle_reg;
        emit_count       = pend_count_reg;
        emit_last        = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (take)
                begin
                    scan_idx_next   = '0;
                    rd_vld_next     = 1'b0;
                    cnt_next        = '0;
                    pend_v_next     = 1'b0;
                    fin_handle_next = '0;
                    fin_count_next  = '0;
                    fin_status_next = ST_DONE;
                    if (cmd.action == ACT_INSERT)
                    begin
                        if (store_full)
                        begin
                            fin_status_next = ST_FULL;
                        end
                        else if (cmd.kind_ok)
                        begin
                            wr_en     = 1'b1;
                            wr_full   = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                end
            end
            B_SCAN:
            begin
                if (!stall)
                begin
                    rd_vld_next = issue;
                    if (issue)
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end
                case (cmd_reg.action)
                    ACT_LOOKUP:
                    begin
                        if (hit && !stall)
                        begin
                            emit             = pend_v_reg;
                            pend_v_next      = 1'b1;
                            pend_handle_next = rd_handle_reg;
                            pend_count_next  = cnt_reg + 1'b1;
                            cnt_next         = cnt_reg + 1'b1;
                        end
                    end
                    ACT_COUNT:
                    begin
                        if (kind_hit)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        if (setend_done)
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = rd_idx_reg;
                            wr_end      = cmd_reg.end_time;
                            rd_vld_next = 1'b0;
                        end
                    end
                endcase
                // wrap up once every slot has been seen
                if (drained)
                begin
                    case (cmd_reg.action)
                        ACT_LOOKUP:
                        begin
                            fin_status_next = pend_v_reg ? ST_MATCH : ST_NOMATCH;
                            fin_handle_next = pend_v_reg ? pend_handle_reg : '0;
                            fin_count_next  = pend_v_reg ? pend_count_reg : '0;
                        end
                        ACT_COUNT:
                        begin
                            fin_status_next = ST_DONE;
                            fin_count_next  = cnt_reg;
                        end
                        default:
                        begin
                            fin_status_next = ST_UNKNOWN;
                        end
                    endcase
                end
            end
            B_FIN:
            begin
                emit        = out_free;
                emit_status = fin_status_reg;
                emit_handle = fin_handle_reg;
                emit_count  = fin_count_reg;
                emit_last   = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            fill_reg      <= '0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            cnt_reg       <= '0;
            pend_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            scan_idx_reg <= scan_idx_next;
            rd_vld_reg   <= rd_vld_next;
            cnt_reg      <= cnt_next;
            pend_v_reg   <= pend_v_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_handle_reg <= pend_handle_next;
        pend_count_reg  <= pend_count_next;
        fin_status_reg  <= fin_status_next;
        fin_handle_reg  <= fin_handle_next;
        fin_count_reg   <= fin_count_next;
        if (take)
        begin
            cmd_reg <= cmd;
        end
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_handle_reg <= emit_handle;
            out_count_reg  <= emit_count;
            out_last_reg   <= emit_last;
        end
    end

    // slot memory write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            end_mem[wr_addr] <= wr_end;
            if (wr_full)
            begin
                kind_mem[wr_addr]   <= cmd.kind;
                handle_mem[wr_addr] <= cmd.handle;
                start_mem[wr_addr]  <= cmd.start_time;
            end
        end
    end

    // slot memory read port, registered
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_idx_reg    <= scan_idx_reg[IDX_W-1:0];
            rd_kind_reg   <= kind_mem[scan_idx_reg[IDX_W-1:0]];
            rd_handle_reg <= handle_mem[scan_idx_reg[IDX_W-1:0]];
            rd_start_reg  <= start_mem[scan_idx_reg[IDX_W-1:0]];
            rd_end_reg    <= end_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_handle = out_handle_reg;
    assign out_count  = out_count_reg;
    assign out_last   = out_last_reg;

    `include "interval_overlap_store_assert.svh"

    `IOS_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= FILL_W'(CAPACITY))
    `IOS_ASSERT_NOW(a_rd_in_fill, rd_vld_reg, FILL_W'(rd_idx_reg) < fill_reg)
    `IOS_ASSERT_NOW(a_insert_room, wr_en && wr_full, !store_full)
    `IOS_ASSERT_NOW(a_pend_lookup, pend_v_reg && (state_reg == B_SCAN), cmd_reg.action == ACT_LOOKUP)
    `IOS_ASSERT_NEXT(a_fin_emits, (state_reg == B_FIN) && out_free,
                     out_valid_reg && out_last_reg)

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import iovs_pkg::*;

    localparam int SLOTS = 64;
    localparam logic [62:0] TMAX = {63{1'b1}};

    // one expected result transaction
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] found_handle;
        logic [6:0]  count;
        logic        last;
    } result_t;

    // directed row: command plus optional typed-in expected last result
    typedef struct packed {
        action_t     action;
        logic [1:0]  kind;
        logic [15:0] handle;
        logic [62:0] t0;
        logic [62:0] t1;
        logic        has_result;
        result_t     result;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [3:0] s_axis_tuser = '0;
    logic [143:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [2:0] m_axis_tuser;
    logic [23:0] m_axis_tdata;
    logic m_axis_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_data = '0;

    // shadow of the store
    logic        sh_valid [SLOTS];
    logic [1:0]  sh_kind [SLOTS];
    logic [15:0] sh_handle [SLOTS];
    logic [62:0] sh_start [SLOTS];
    logic [62:0] sh_end [SLOTS];
    int          sh_fill;
    logic [1:0]  sh_msg_kind;

    result_t pending_results[$];
    int errors = 0;
    int n_results = 0;
    int n_items = 0;
    int n_matches = 0;
    int send_idle = 0;
    int recv_idle = 0;
    row_t rows[$];

    interval_overlap_store i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tuser(m_axis_tuser), .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // overlap rule, point entries of other kinds always hit
    function automatic bit entry_hits(int i, logic [62:0] qs, logic [62:0] qe);
        logic [62:0] s;
        logic [62:0] e;
        s = sh_start[i];
        e = sh_end[i];
        if (s == e && sh_kind[i] != sh_msg_kind)
            return 1;
        if (s >= qs && s <= qe)
            return 1;
        if (e >= qs && e <= qe)
            return 1;
        return s < qs && e > qe;
    endfunction

    // update shadow store and queue the results of one command
    task automatic predict_store(action_t act, logic [1:0] kind, logic [15:0] hdl,
                                 logic [62:0] t0, logic [62:0] t1);
        int n;
        bit hit;
        n = 0;
        hit = 0;
        case (act)
            ACT_INSERT:
            begin
                if (sh_fill >= SLOTS)
                    pending_results.push_back('{ST_FULL, 16'd0, 7'd0, 1'b1});
                else
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!hit && !sh_valid[i])
                        begin
                            sh_valid[i] = 1'b1;
                            sh_kind[i] = kind;
                            sh_handle[i] = hdl;
                            sh_start[i] = t0;
                            sh_end[i] = t1;
                            sh_fill++;
                            hit = 1;
                        end
                    end
                    pending_results.push_back('{ST_DONE, 16'd0, 7'd0, 1'b1});
                end
            end
            ACT_SETEND:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!hit && sh_valid[i] && sh_handle[i] == hdl)
                    begin
                        sh_end[i] = t1;
                        hit = 1;
                    end
                end
                pending_results.push_back('{hit ? ST_DONE : ST_UNKNOWN, 16'd0, 7'd0, 1'b1});
            end
            ACT_LOOKUP:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (sh_valid[i] && sh_kind[i] == kind && entry_hits(i, t0, t1))
                    begin
                        n++;
                        pending_results.push_back('{ST_MATCH, sh_handle[i], 7'(n), 1'b0});
                    end
                end
                n_matches += n;
                if (n == 0)
                    pending_results.push_back('{ST_NOMATCH, 16'd0, 7'd0, 1'b1});
                else
                    pending_results[$].last = 1'b1;
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (sh_valid[i] && sh_kind[i] == kind)
                        n++;
                pending_results.push_back('{ST_DONE, 16'd0, 7'(n), 1'b1});
            end
        endcase
    endtask

    // send one command transaction, valid drops only while idling
    task automatic send_cmd(action_t act, logic [1:0] kind, logic [15:0] hdl,
                            logic [62:0] t0, logic [62:0] t1);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        predict_store(act, kind, hdl, t0, t1);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {kind, act};
        s_axis_tdata <= {2'b00, t1, t0, hdl};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        n_items++;
    endtask

    // stop sending, wait until the block has drained, then idle before returning
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_msg_kind(logic [1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sh_msg_kind = value;
    endtask

    // random time, clustered so overlaps are common, extremes sometimes
    function automatic logic [62:0] rand_time();
        case ($urandom_range(9))
            0: return TMAX;
            1: return '0;
            2: return 63'({$urandom, $urandom});
            default: return 63'($urandom_range(60));
        endcase
    endfunction

    task automatic random_phase(int items, logic [15:0] hmax);
        action_t act;
        int pick;
        for (int k = 0; k < items; k++)
        begin
            pick = $urandom_range(99);
            if (sh_fill >= SLOTS && pick < 40)
                pick = 40 + $urandom_range(59);
            act = pick < 35 ? ACT_INSERT : pick < 50 ? ACT_SETEND :
                  pick < 85 ? ACT_LOOKUP : ACT_COUNT;
            send_cmd(act, 2'($urandom_range(3)), 16'($urandom_range(hmax)),
                     rand_time(), rand_time());
        end
    endtask

    // result side: random stalls and field checks
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[22:16], m_axis_tlast};
                n_results++;
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result transaction, actual %p", $realtime, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $realtime, want, got);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // guard against a hung block
    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        row_t r;
        for (int i = 0; i < SLOTS; i++)
            sh_valid[i] = 1'b0;
        sh_fill = 0;
        sh_msg_kind = 2'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: empty store, extremes, point entries, reversed spans, bad handles
        rows.push_back('{ACT_COUNT, 2'd0, 16'd0, 63'd0, 63'd0, 1'b1, '{ST_DONE, 16'd0, 7'd0, 1'b1}});
        rows.push_back('{ACT_LOOKUP, 2'd3, 16'd0, 63'd0, TMAX, 1'b1, '{ST_NOMATCH, 16'd0, 7'd0, 1'b1}});
        rows.push_back('{ACT_SETEND, 2'd0, 16'hffff, 63'd0, 63'd5, 1'b1, '{ST_UNKNOWN, 16'd0, 7'd0, 1'b1}});
        rows.push_back('{ACT_INSERT, 2'd0, 16'hffff, 63'd0, TMAX, 1'b1, '{ST_DONE, 16'd0, 7'd0, 1'b1}});
        rows.push_back('{ACT_INSERT, 2'd0, 16'h0000, 63'd7, 63'd7, 1'b0, '0});
        rows.push_back('{ACT_INSERT, 2'd1, 16'h1234, 63'd9, 63'd9, 1'b0, '0});
        rows.push_back('{ACT_INSERT, 2'd3, 16'haaaa, TMAX, 63'd3, 1'b0, '0});
        rows.push_back('{ACT_INSERT, 2'd2, 16'h5555, 63'd10, 63'd20, 1'b0, '0});
        rows.push_back('{ACT_INSERT, 2'd2, 16'h5555, 63'd30, 63'd40, 1'b0, '0});
        rows.push_back('{ACT_LOOKUP, 2'd0, 16'd0, 63'd100, 63'd200, 1'b0, '0});
        rows.push_back('{ACT_LOOKUP, 2'd1, 16'd0, 63'd100, 63'd200, 1'b0, '0});
        rows.push_back('{ACT_LOOKUP, 2'd2, 16'd0, 63'd15, 63'd35, 1'b0, '0});
        rows.push_back('{ACT_LOOKUP, 2'd2, 16'd0, 63'd12, 63'd14, 1'b0, '0});
        rows.push_back('{ACT_LOOKUP, 2'd2, 16'd0, 63'd35, 63'd15, 1'b0, '0});
        rows.push_back('{ACT_LOOKUP, 2'd3, 16'd0, 63'd0, TMAX, 1'b0, '0});
        rows.push_back('{ACT_SETEND, 2'd0, 16'h5555, 63'd0, 63'd50, 1'b1, '{ST_DONE, 16'd0, 7'd0, 1'b1}});
        rows.push_back('{ACT_LOOKUP, 2'd2, 16'd0, 63'd45, 63'd60, 1'b0, '0});
        rows.push_back('{ACT_COUNT, 2'd2, 16'd0, 63'd0, 63'd0, 1'b0, '0});
        rows.push_back('{ACT_COUNT, 2'd3, 16'd0, TMAX, TMAX, 1'b0, '0});
        foreach (rows[j])
        begin
            r = rows[j];
            send_cmd(r.action, r.kind, r.handle, r.t0, r.t1);
            if (r.has_result && pending_results[$] !== r.result)
            begin
                errors++;
                $display("%0t: row %0d prediction, expected %p, actual %p",
                         $realtime, j, r.result, pending_results[$]);
            end
        end
        drain();

        // point entries of the message kind now need true overlap
        write_msg_kind(2'd1);
        send_cmd(ACT_LOOKUP, 2'd1, 16'd0, 63'd100, 63'd200);
        send_cmd(ACT_LOOKUP, 2'd0, 16'd0, 63'd100, 63'd200);
        drain();

        // random phases under shifting stall patterns and register values
        send_idle = 22;
        recv_idle = 64;
        random_phase(130, 16'd40);
        drain();
        write_msg_kind(2'd3);
        send_idle = 64;
        recv_idle = 22;
        random_phase(130, 16'hffff);
        drain();
        write_msg_kind(2'd2);
        send_idle = 0;
        recv_idle = 0;
        random_phase(70, 16'd40);
        drain();
        write_msg_kind(2'd0);
        // store is full by now: fill pressure, then a burst without idling
        for (int k = 0; k < 4; k++)
            send_cmd(ACT_INSERT, 2'($urandom_range(3)), 16'($urandom), rand_time(), rand_time());
        random_phase(60, 16'd40);
        drain();

        $display("tb: %0d commands, %0d result transactions, %0d lookup matches, store fill %0d",
                 n_items, n_results, n_matches, sh_fill);
        $display("tb: message kind swept over 0..3, stalls on both sides and none");
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// File: interval_overlap_store.f
+incdir+hdl
hdl/iovs_pkg.sv
hdl/iovs_front.sv
hdl/iovs_back.sv
hdl/interval_overlap_store.sv
tb/testbench.sv
